// ===== rtl/core/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants
// Payload structs, angle constants and the CORDIC arctangent table used by
// the Euler-angle to rotation matrix converter.
// ----------------------------------------------------------------------------
package e2r_pkg;

   // One orientation request: degrees with 6 fraction bits.
   typedef struct packed {
      logic signed [15:0] pitch_deg;
      logic signed [15:0] yaw_deg;
      logic signed [15:0] roll_deg;
   } req_type;

   // One rotation matrix result.
   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rsp_type;

   localparam int ANG_FULL  = 23040;
   localparam int ANG_HALF  = 11520;
   localparam int ANG_QUART = 5760;
   localparam int TABLE_LEN = 24;

   // Radians per degree*64 in Q30, and the CORDIC start value 0.60725 in Q30.
   localparam logic signed [19:0] RAD_PER_DEG64 = 20'sd292818;
   localparam logic signed [33:0] CORDIC_X0     = 34'sd652032874;

   // Sine and cosine width in Q2.30; CORDIC datapath width.
   localparam int TRIG_W = 32;
   localparam int DP_W   = 34;

   localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

endpackage

// ===== rtl/core/e2r_lane.sv =====
// ----------------------------------------------------------------------------
// e2r_lane: pipelined sine and cosine of one angle
// Folds the angle into a quarter turn, converts it to radians and runs an
// unrolled CORDIC rotation, one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module e2r_lane #(
   parameter int TRIG_STAGES = 16
) (
   input  logic                            clock,
   input  logic signed [15:0]              angle,
   output logic signed [e2r_pkg::TRIG_W-1:0] sin_out,
   output logic signed [e2r_pkg::TRIG_W-1:0] cos_out
);

   localparam int NST = (TRIG_STAGES < e2r_pkg::TABLE_LEN) ? TRIG_STAGES
                                                           : e2r_pkg::TABLE_LEN;
   localparam int W = e2r_pkg::DP_W;

   logic signed [16:0] wrap;
   logic signed [16:0] fold;
   logic               neg;
   logic signed [W-1:0] z_in;

   logic signed [W-1:0] x_ff [0:NST];
   logic signed [W-1:0] y_ff [0:NST];
   logic signed [W-1:0] z_ff [0:NST];
   logic                neg_ff [0:NST];

   // Wrap into (-180, 180] degrees, then fold into a quarter turn.
   always_comb begin
      wrap = 17'(angle);
      if (wrap > 17'sd11520) begin
         wrap = wrap - 17'sd23040;
      end else if (wrap <= -17'sd11520) begin
         wrap = wrap + 17'sd23040;
      end
      fold = wrap;
      neg  = 1'b0;
      if (wrap > 17'sd5760) begin
         fold = wrap - 17'sd11520;
         neg  = 1'b1;
      end else if (wrap < -17'sd5760) begin
         fold = wrap + 17'sd11520;
         neg  = 1'b1;
      end
      z_in = W'(fold) * W'(e2r_pkg::RAD_PER_DEG64);
   end

   // Entry stage: radians and start vector.
   always_ff @(posedge clock) begin
      x_ff[0]   <= e2r_pkg::CORDIC_X0;
      y_ff[0]   <= '0;
      z_ff[0]   <= z_in;
      neg_ff[0] <= neg;
   end

   // One micro-rotation per stage.
   for (genvar g = 0; g < NST; g++) begin : g_stage
      logic signed [W-1:0] atan_v;
      assign atan_v = W'(signed'({1'b0, e2r_pkg::ATAN_Q30[g]}));
      always_ff @(posedge clock) begin
         if (z_ff[g] >= 0) begin
            x_ff[g+1] <= x_ff[g] - (y_ff[g] >>> g);
            y_ff[g+1] <= y_ff[g] + (x_ff[g] >>> g);
            z_ff[g+1] <= z_ff[g] - atan_v;
         end else begin
            x_ff[g+1] <= x_ff[g] + (y_ff[g] >>> g);
            y_ff[g+1] <= y_ff[g] - (x_ff[g] >>> g);
            z_ff[g+1] <= z_ff[g] + atan_v;
         end
         neg_ff[g+1] <= neg_ff[g];
      end
   end

   // Undo the half-turn fold.
   assign sin_out = e2r_pkg::TRIG_W'(neg_ff[NST] ? -y_ff[NST] : y_ff[NST]);
   assign cos_out = e2r_pkg::TRIG_W'(neg_ff[NST] ? -x_ff[NST] : x_ff[NST]);

endmodule

// ===== rtl/core/e2r_merge.sv =====
// ----------------------------------------------------------------------------
// e2r_merge: matrix assembly from the three lanes
// Three registered steps: cross products, products with sin pitch, then the
// sums, rounding to the output format and clamping.
// ----------------------------------------------------------------------------
module e2r_merge #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic signed [e2r_pkg::TRIG_W-1:0] sp,
   input  logic signed [e2r_pkg::TRIG_W-1:0] cp,
   input  logic signed [e2r_pkg::TRIG_W-1:0] sy,
   input  logic signed [e2r_pkg::TRIG_W-1:0] cy,
   input  logic signed [e2r_pkg::TRIG_W-1:0] sr,
   input  logic signed [e2r_pkg::TRIG_W-1:0] cr,
   output e2r_pkg::rsp_type                  rsp
);

   localparam int TW  = e2r_pkg::TRIG_W;
   localparam int SW  = 40;
   localparam int SH  = (OUT_FRAC_BITS < 30) ? 30 - OUT_FRAC_BITS : 0;
   localparam int LIM = (OUT_FRAC_BITS < 15) ? (1 << OUT_FRAC_BITS) : 32767;
   localparam logic signed [SW-1:0] LIM_V = SW'(LIM);

   // Product of two Q30 values, rounded half up back to Q30.
   function automatic logic signed [TW-1:0] mulq(logic signed [TW-1:0] a,
                                                 logic signed [TW-1:0] b);
      logic signed [2*TW-1:0] p;
      p = (2*TW)'(a) * (2*TW)'(b) + (64'sd1 <<< 29);
      return TW'(p >>> 30);
   endfunction

   // Round from Q30 to the output format and clamp.
   function automatic logic [15:0] to_out(logic signed [SW-1:0] v);
      logic signed [SW-1:0] o;
      if (SH == 0) begin
         o = v;
      end else begin
         o = (v + (SW'(1) <<< (SH - 1))) >>> SH;
      end
      if (o > LIM_V) begin
         o = LIM_V;
      end else if (o < -LIM_V) begin
         o = -LIM_V;
      end
      return o[15:0];
   endfunction

   logic signed [TW-1:0] crcy_ff, crsy_ff, srcy_ff, srsy_ff;
   logic signed [TW-1:0] cpcy_ff, cpsy_ff, srcp_ff, crcp_ff, sp_ff;
   logic signed [TW-1:0] a01_ff, a02_ff, a11_ff, a12_ff;
   logic signed [TW-1:0] b_crsy_ff, b_srsy_ff, b_crcy_ff, b_srcy_ff;
   logic signed [TW-1:0] b_cpcy_ff, b_cpsy_ff, b_srcp_ff, b_crcp_ff, b_sp_ff;
   e2r_pkg::rsp_type     rsp_ff;

   // Step one: roll/yaw cross products and the simple entries.
   always_ff @(posedge clock) begin
      crcy_ff <= mulq(cr, cy);
      crsy_ff <= mulq(cr, sy);
      srcy_ff <= mulq(sr, cy);
      srsy_ff <= mulq(sr, sy);
      cpcy_ff <= mulq(cp, cy);
      cpsy_ff <= mulq(cp, sy);
      srcp_ff <= mulq(sr, cp);
      crcp_ff <= mulq(cr, cp);
      sp_ff   <= sp;
   end

   // Step two: cross products scaled by sin pitch.
   always_ff @(posedge clock) begin
      a01_ff    <= mulq(sp_ff, srcy_ff);
      a02_ff    <= mulq(sp_ff, crcy_ff);
      a11_ff    <= mulq(sp_ff, srsy_ff);
      a12_ff    <= mulq(sp_ff, crsy_ff);
      b_crsy_ff <= crsy_ff;
      b_srsy_ff <= srsy_ff;
      b_crcy_ff <= crcy_ff;
      b_srcy_ff <= srcy_ff;
      b_cpcy_ff <= cpcy_ff;
      b_cpsy_ff <= cpsy_ff;
      b_srcp_ff <= srcp_ff;
      b_crcp_ff <= crcp_ff;
      b_sp_ff   <= sp_ff;
   end

   // Step three: sums and output formatting.
   always_ff @(posedge clock) begin
      rsp_ff.m00 <= to_out(SW'(b_cpcy_ff));
      rsp_ff.m01 <= to_out(SW'(a01_ff) - SW'(b_crsy_ff));
      rsp_ff.m02 <= to_out(SW'(a02_ff) + SW'(b_srsy_ff));
      rsp_ff.m10 <= to_out(SW'(b_cpsy_ff));
      rsp_ff.m11 <= to_out(SW'(a11_ff) + SW'(b_crcy_ff));
      rsp_ff.m12 <= to_out(SW'(a12_ff) - SW'(b_srcy_ff));
      rsp_ff.m20 <= to_out(-SW'(b_sp_ff));
      rsp_ff.m21 <= to_out(SW'(b_srcp_ff));
      rsp_ff.m22 <= to_out(SW'(b_crcp_ff));
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/core/euler_to_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top: ZYX Euler angles to rotation matrix
// Converts pitch, yaw and roll to the nine entries of the rotation matrix.
// ----------------------------------------------------------------------------
// The block is fully pipelined and takes one request every clock cycle; busy
// is never raised. Each result appears on rsp with rsp_valid high for one
// cycle, after its request passes the angle-reduction entry register, one
// register per CORDIC stage in the three angle lanes (TRIG_STAGES, capped
// at 24), and the three registered steps of matrix assembly. The receiver
// cannot stall, so results must be taken when shown.
module euler_to_rotation_matrix_top #(
   parameter int TRIG_STAGES   = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  e2r_pkg::req_type  req,
   output logic              rsp_valid,
   output e2r_pkg::rsp_type  rsp
);

   localparam int NST = (TRIG_STAGES < e2r_pkg::TABLE_LEN) ? TRIG_STAGES
                                                           : e2r_pkg::TABLE_LEN;
   localparam int LAT = NST + 4;

   logic signed [e2r_pkg::TRIG_W-1:0] sp, cp, sy, cy, sr, cr;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign busy = 1'b0;

   // Angle lanes.
   e2r_lane #(.TRIG_STAGES(TRIG_STAGES)) u_pitch (
      .clock(clock), .angle(req.pitch_deg), .sin_out(sp), .cos_out(cp));
   e2r_lane #(.TRIG_STAGES(TRIG_STAGES)) u_yaw (
      .clock(clock), .angle(req.yaw_deg), .sin_out(sy), .cos_out(cy));
   e2r_lane #(.TRIG_STAGES(TRIG_STAGES)) u_roll (
      .clock(clock), .angle(req.roll_deg), .sin_out(sr), .cos_out(cr));

   // Matrix assembly.
   e2r_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
      .clock(clock), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .rsp(rsp));

   // Valid tracking alongside the data pipeline.
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // A result strobe always traces back to a request transfer.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result strobe without matching request");

   // The pitch entry stays within the clamp range.
   a_m20_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.m20 <= 16'sd16384 || OUT_FRAC_BITS > 14) &&
                    (rsp.m20 >= -16'sd16384 || OUT_FRAC_BITS > 14))
      else $error("m20 outside clamp range");

   // The pipeline is never held off.
   a_never_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the Euler-angle to rotation matrix converter
// Sends pitch/yaw/roll requests, predicts each matrix with a fixed-point
// CORDIC model of its own, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STAGES    = 16;
   localparam int FRAC_BITS = 14;
   localparam int LATENCY   = STAGES + 4;
   localparam longint CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   e2r_pkg::req_type req = '0;
   logic             rsp_valid;
   e2r_pkg::rsp_type rsp;

   e2r_pkg::rsp_type matrix_queue[$];
   int      error_count = 0;
   longint  cycle_count = 0;
   int      idle_pct = 0;

   euler_to_rotation_matrix_top #(
      .TRIG_STAGES(STAGES), .OUT_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always #6 clock = ~clock;

   // Arithmetic shift right of a 64-bit signed value.
   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   // Product of two Q30 values, rounded half up back to Q30.
   function automatic longint mul_q30(longint a, longint b);
      return shr(a * b + (64'sd1 <<< 29), 30);
   endfunction

   // Sine and cosine of an angle in degrees*64, Q30, by CORDIC.
   function automatic void angle_sin_cos(input logic signed [15:0] deg,
                                         output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      bit     flip;
      r = longint'(deg) % e2r_pkg::ANG_FULL;
      flip = 0;
      if (r > e2r_pkg::ANG_HALF) r -= e2r_pkg::ANG_FULL;
      if (r <= -e2r_pkg::ANG_HALF) r += e2r_pkg::ANG_FULL;
      if (r > e2r_pkg::ANG_QUART) begin
         r -= e2r_pkg::ANG_HALF;
         flip = 1;
      end else if (r < -e2r_pkg::ANG_QUART) begin
         r += e2r_pkg::ANG_HALF;
         flip = 1;
      end
      x = 652032874;
      y = 0;
      z = r * 292818;
      for (int i = 0; i < STAGES && i < e2r_pkg::TABLE_LEN; i++) begin
         dx = shr(y, i);
         dy = shr(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(e2r_pkg::ATAN_Q30[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(e2r_pkg::ATAN_Q30[i]);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   // Round a Q30 value to the output format and clamp it.
   function automatic logic signed [15:0] to_entry(longint v);
      longint o, lim;
      o = shr(v + (64'sd1 <<< (29 - FRAC_BITS)), 30 - FRAC_BITS);
      lim = (FRAC_BITS < 15) ? (64'sd1 <<< FRAC_BITS) : 32767;
      if (o > lim) o = lim;
      if (o < -lim) o = -lim;
      return o[15:0];
   endfunction

   // Expected rotation matrix for one request.
   function automatic e2r_pkg::rsp_type rotation_matrix(e2r_pkg::req_type q);
      longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
      e2r_pkg::rsp_type m;
      angle_sin_cos(q.pitch_deg, sp, cp);
      angle_sin_cos(q.yaw_deg, sy, cy);
      angle_sin_cos(q.roll_deg, sr, cr);
      crcy = mul_q30(cr, cy);
      crsy = mul_q30(cr, sy);
      srcy = mul_q30(sr, cy);
      srsy = mul_q30(sr, sy);
      m.m00 = to_entry(mul_q30(cp, cy));
      m.m01 = to_entry(mul_q30(sp, srcy) - crsy);
      m.m02 = to_entry(mul_q30(sp, crcy) + srsy);
      m.m10 = to_entry(mul_q30(cp, sy));
      m.m11 = to_entry(mul_q30(sp, srsy) + crcy);
      m.m12 = to_entry(mul_q30(sp, crsy) - srcy);
      m.m20 = to_entry(-sp);
      m.m21 = to_entry(mul_q30(sr, cp));
      m.m22 = to_entry(mul_q30(cr, cp));
      return m;
   endfunction

   // Send one request; the prediction is queued when the transfer happens.
   task automatic send_angles(input logic [15:0] p, input logic [15:0] y,
                              input logic [15:0] r);
      e2r_pkg::req_type q;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      q.pitch_deg = p;
      q.yaw_deg = y;
      q.roll_deg = r;
      req <= q;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      matrix_queue.push_back(rotation_matrix(q));
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(3))
         0: return 16'($urandom_range(46080) - 23040);
         1: return 16'($urandom_range(16'hFFFF));
         2: return 16'(e2r_pkg::ANG_QUART * ($urandom_range(8) - 4))
                   + 16'($urandom_range(2)) - 16'd1;
         default: return 16'($urandom_range(11520) - 5760);
      endcase
   endfunction

   // Compare each result with the oldest prediction.
   always @(posedge clock) begin
      e2r_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (matrix_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp);
            error_count++;
         end else begin
            want = matrix_queue.pop_front();
            if (want.m00 !== rsp.m00) begin
               $display("%0t: m00 expected %0d actual %0d", $time, want.m00, rsp.m00);
               error_count++;
            end
            if (want.m01 !== rsp.m01) begin
               $display("%0t: m01 expected %0d actual %0d", $time, want.m01, rsp.m01);
               error_count++;
            end
            if (want.m02 !== rsp.m02) begin
               $display("%0t: m02 expected %0d actual %0d", $time, want.m02, rsp.m02);
               error_count++;
            end
            if (want.m10 !== rsp.m10) begin
               $display("%0t: m10 expected %0d actual %0d", $time, want.m10, rsp.m10);
               error_count++;
            end
            if (want.m11 !== rsp.m11) begin
               $display("%0t: m11 expected %0d actual %0d", $time, want.m11, rsp.m11);
               error_count++;
            end
            if (want.m12 !== rsp.m12) begin
               $display("%0t: m12 expected %0d actual %0d", $time, want.m12, rsp.m12);
               error_count++;
            end
            if (want.m20 !== rsp.m20) begin
               $display("%0t: m20 expected %0d actual %0d", $time, want.m20, rsp.m20);
               error_count++;
            end
            if (want.m21 !== rsp.m21) begin
               $display("%0t: m21 expected %0d actual %0d", $time, want.m21, rsp.m21);
               error_count++;
            end
            if (want.m22 !== rsp.m22) begin
               $display("%0t: m22 expected %0d actual %0d", $time, want.m22, rsp.m22);
               error_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Field extremes, quadrant edges and wrapping patterns.
   task automatic test_directed();
      logic [15:0] corner[12] = '{16'h0000, 16'd5760, -16'sd5760, 16'd5761, -16'sd5761,
                                  16'd11520, -16'sd11520, 16'd23040, -16'sd23040,
                                  16'h7FFF, 16'h8000, 16'hFFFF};
      for (int i = 0; i < 12; i++)
         send_angles(corner[i], corner[(i + 4) % 12], corner[(i + 8) % 12]);
      send_angles(16'd5760, 16'd0, 16'd0);
      send_angles(16'd0, 16'd5760, 16'd0);
      send_angles(16'd0, 16'd0, 16'd5760);
      send_angles(16'h5555, 16'hAAAA, 16'h0001);
   endtask

   // Random angles over several sender idle rates.
   task automatic test_random(input int count, input int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++)
         send_angles(rand_angle(), rand_angle(), rand_angle());
      idle_pct = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500, 0);
      test_random(300, 84);
      test_random(400, 30);
      test_random(400, 0);
      start <= 1'b0;
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
